### hdl/itad_pkg.sv
`default_nettype none

package itad_pkg;

   localparam int BIN_BITS       = 32;
   localparam int BCD_DIGITS     = 10;
   localparam int NIB_BITS       = 4;
   localparam int BCD_BITS       = BCD_DIGITS * NIB_BITS;
   localparam int WORD_BITS      = 64;
   localparam int DIG_SLOTS      = WORD_BITS / NIB_BITS;
   localparam int LEFT_BITS      = $clog2(DIG_SLOTS + 1);
   localparam int CHAR_BITS      = 8;
   localparam int OP_BITS        = 3;
   localparam int TOTAL_BITS     = 32;
   localparam int COUNT_BITS_DEF = 32;

   localparam logic [CHAR_BITS-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_A = 8'h41;
   localparam logic [NIB_BITS-1:0]  DEC_LIMIT  = 4'd10;
   localparam logic [NIB_BITS-1:0]  BCD_ADJ_MIN = 4'd5;
   localparam logic [NIB_BITS-1:0]  BCD_ADJ    = 4'd3;

   typedef enum logic [OP_BITS-1:0] {
      OP_SDEC = 3'd0,
      OP_UDEC = 3'd1,
      OP_HEXL = 3'd2,
      OP_HEXU = 3'd3,
      OP_PTR  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                start;
      logic [BIN_BITS-1:0] bin;
   } cvt_req_type;

   typedef struct packed {
      logic                done;
      logic [BCD_BITS-1:0] bcd;
   } cvt_rsp_type;

   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [NIB_BITS-1:0] nib,
                                                       input logic upper);
      logic [CHAR_BITS-1:0] wide;
      begin
         wide = {{(CHAR_BITS-NIB_BITS){1'b0}}, nib};
         if (nib < DEC_LIMIT) begin
            digit_char = CH_ZERO + wide;
         end else if (upper) begin
            digit_char = CH_UPPER_A + wide - {{(CHAR_BITS-NIB_BITS){1'b0}}, DEC_LIMIT};
         end else begin
            digit_char = CH_LOWER_A + wide - {{(CHAR_BITS-NIB_BITS){1'b0}}, DEC_LIMIT};
         end
      end
   endfunction

endpackage

`default_nettype wire

### hdl/itad_if.sv
`default_nettype none

interface itad_req_if;
   logic                                valid;
   logic                                ready;
   logic [itad_pkg::OP_BITS-1:0]        op;
   logic [itad_pkg::WORD_BITS-1:0]      value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

interface itad_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [itad_pkg::CHAR_BITS-1:0]      char_out;
   logic                                is_last;
   logic [itad_pkg::TOTAL_BITS-1:0]     chars_total;

   modport source (output valid, output char_out, output is_last, output chars_total,
                   input ready);
   modport sink   (input valid, input char_out, input is_last, input chars_total,
                   output ready);
endinterface

`default_nettype wire

### hdl/itad_dabble.sv
`default_nettype none

// Binary to BCD by shift-and-add-3, one input bit per cycle.
module itad_dabble (
   input  wire                    clock,
   input  wire                    reset,
   input  itad_pkg::cvt_req_type  cvt_req,
   output itad_pkg::cvt_rsp_type  cvt_rsp
);

   localparam int STEP_BITS = $clog2(itad_pkg::BIN_BITS);
   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(itad_pkg::BIN_BITS - 1);

   logic                              run_ff,  run_in;
   logic                              done_ff, done_in;
   logic [STEP_BITS-1:0]              step_ff, step_in;
   logic [itad_pkg::BIN_BITS-1:0]     bin_ff,  bin_in;
   logic [itad_pkg::BCD_BITS-1:0]     bcd_ff,  bcd_in;
   logic [itad_pkg::BCD_BITS-1:0]     bcd_adj;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      bcd_adj = bcd_ff;
      for (int i = 0; i < itad_pkg::BCD_DIGITS; i++) begin
         if (bcd_ff[i*itad_pkg::NIB_BITS +: itad_pkg::NIB_BITS] >= itad_pkg::BCD_ADJ_MIN) begin
            bcd_adj[i*itad_pkg::NIB_BITS +: itad_pkg::NIB_BITS] =
               bcd_ff[i*itad_pkg::NIB_BITS +: itad_pkg::NIB_BITS] + itad_pkg::BCD_ADJ;
         end
      end
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      if (cvt_req.start) begin
         run_in  = 1'b1;
         step_in = '0;
         bin_in  = cvt_req.bin;
         bcd_in  = '0;
      end else if (run_ff) begin
         bcd_in  = {bcd_adj[itad_pkg::BCD_BITS-2:0], bin_ff[itad_pkg::BIN_BITS-1]};
         bin_in  = {bin_ff[itad_pkg::BIN_BITS-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign cvt_rsp.done = done_ff;
   assign cvt_rsp.bcd  = bcd_ff;

`ifndef SYNTH
   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff)
      else $error("converter done while still running");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      cvt_req.start |=> run_ff && step_ff == '0)
      else $error("converter did not start");

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      (run_ff && !cvt_req.start && step_ff == STEP_LAST) |=> done_ff)
      else $error("converter missed its done pulse");
`endif

endmodule

`default_nettype wire

### hdl/integer_to_ascii_digits_top.sv
`default_nettype none

// Channel  Dir  Payload                              Transfer
// req_chan in   op[2:0], value[63:0]                 valid && ready
// rsp_chan out  char_out[7:0], is_last, chars_total  valid && ready
//
// Hex: accept in idle, then skip shifts out each leading zero digit and
// leaves, then emit sends the characters in turn. Decimal first runs the
// converter and loads its BCD digits; a minus sign adds one character.
// req_chan.ready is high only in idle; a stalled rsp_chan holds emit.
// Reset is synchronous and clears the sequencer, count and output valid flag.
module integer_to_ascii_digits_top #(
   parameter int COUNT_BITS = itad_pkg::COUNT_BITS_DEF
) (
   input  wire          clock,
   input  wire          reset,
   itad_req_if.sink     req_chan,
   itad_rsp_if.source   rsp_chan
);

   itad_pkg::state_type                state_ff, state_in;
   logic [itad_pkg::WORD_BITS-1:0]     digits_ff, digits_in;
   logic [itad_pkg::LEFT_BITS-1:0]     left_ff, left_in;
   logic                               neg_ff, neg_in;
   logic                               upper_ff, upper_in;
   logic [COUNT_BITS-1:0]              count_ff, count_in;
   logic [COUNT_BITS-1:0]              count_next;
   logic [itad_pkg::TOTAL_BITS-1:0]    count_low;
   logic                               out_valid_ff, out_valid_in;
   logic [itad_pkg::CHAR_BITS-1:0]     out_char_ff, out_char_in;
   logic                               out_last_ff, out_last_in;
   logic [itad_pkg::TOTAL_BITS-1:0]    out_total_ff, out_total_in;
   logic                               slot_free;
   logic [itad_pkg::NIB_BITS-1:0]      top_nib;
   logic [itad_pkg::BIN_BITS-1:0]      low_word;
   logic [itad_pkg::BIN_BITS-1:0]      magnitude;
   itad_pkg::cvt_req_type              cvt_req;
   itad_pkg::cvt_rsp_type              cvt_rsp;

   localparam logic [itad_pkg::LEFT_BITS-1:0] LEFT_FULL = itad_pkg::LEFT_BITS'(itad_pkg::DIG_SLOTS);
   localparam logic [itad_pkg::LEFT_BITS-1:0] LEFT_ONE  = itad_pkg::LEFT_BITS'(1);

   itad_dabble u_dabble (
      .clock   (clock),
      .reset   (reset),
      .cvt_req (cvt_req),
      .cvt_rsp (cvt_rsp)
   );

   assign count_next = count_ff + 1'b1;

   generate
      if (COUNT_BITS >= itad_pkg::TOTAL_BITS) begin : g_total_wide
         assign count_low = count_next[itad_pkg::TOTAL_BITS-1:0];
      end else begin : g_total_narrow
         assign count_low = {{(itad_pkg::TOTAL_BITS-COUNT_BITS){1'b0}}, count_next};
      end
   endgenerate

   assign slot_free = !out_valid_ff || rsp_chan.ready;
   assign top_nib   = digits_ff[itad_pkg::WORD_BITS-1 -: itad_pkg::NIB_BITS];
   assign low_word  = req_chan.value[itad_pkg::BIN_BITS-1:0];
   // two's complement of the most negative value is its own magnitude unsigned
   assign magnitude = (req_chan.op == itad_pkg::OP_SDEC && low_word[itad_pkg::BIN_BITS-1])
                      ? (~low_word + 1'b1) : low_word;

   always_comb begin
      state_in     = state_ff;
      digits_in    = digits_ff;
      left_in      = left_ff;
      neg_in       = neg_ff;
      upper_in     = upper_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_total_in = out_total_ff;
      cvt_req.start = 1'b0;
      cvt_req.bin   = magnitude;
      req_chan.ready = (state_ff == itad_pkg::ST_IDLE);

      case (state_ff)
         itad_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               upper_in = 1'b0;
               neg_in   = 1'b0;
               left_in  = LEFT_FULL;
               case (req_chan.op)
                  itad_pkg::OP_SDEC: begin
                     neg_in        = low_word[itad_pkg::BIN_BITS-1];
                     cvt_req.start = 1'b1;
                     state_in      = itad_pkg::ST_CONVERT;
                  end
                  itad_pkg::OP_UDEC: begin
                     cvt_req.start = 1'b1;
                     state_in      = itad_pkg::ST_CONVERT;
                  end
                  itad_pkg::OP_HEXL: begin
                     digits_in = {{(itad_pkg::WORD_BITS-itad_pkg::BIN_BITS){1'b0}}, low_word};
                     state_in  = itad_pkg::ST_SKIP;
                  end
                  itad_pkg::OP_HEXU: begin
                     digits_in = {{(itad_pkg::WORD_BITS-itad_pkg::BIN_BITS){1'b0}}, low_word};
                     upper_in  = 1'b1;
                     state_in  = itad_pkg::ST_SKIP;
                  end
                  itad_pkg::OP_PTR: begin
                     digits_in = req_chan.value;
                     state_in  = itad_pkg::ST_SKIP;
                  end
                  default: begin
                     // undefined format: drop the item
                     state_in = itad_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         itad_pkg::ST_CONVERT: begin
            if (cvt_rsp.done) begin
               digits_in = {{(itad_pkg::WORD_BITS-itad_pkg::BCD_BITS){1'b0}}, cvt_rsp.bcd};
               left_in   = LEFT_FULL;
               state_in  = itad_pkg::ST_SKIP;
            end
         end
         itad_pkg::ST_SKIP: begin
            // drop leading zeros, keep at least one digit
            if (top_nib == '0 && left_ff != LEFT_ONE) begin
               digits_in = digits_ff << itad_pkg::NIB_BITS;
               left_in   = left_ff - 1'b1;
            end else begin
               state_in = itad_pkg::ST_EMIT;
            end
         end
         itad_pkg::ST_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               count_in     = count_next;
               out_total_in = count_low;
               if (neg_ff) begin
                  out_char_in = itad_pkg::CH_MINUS;
                  out_last_in = 1'b0;
                  neg_in      = 1'b0;
               end else begin
                  out_char_in = itad_pkg::digit_char(top_nib, upper_ff);
                  out_last_in = (left_ff == LEFT_ONE);
                  digits_in   = digits_ff << itad_pkg::NIB_BITS;
                  left_in     = left_ff - 1'b1;
                  if (left_ff == LEFT_ONE) begin
                     state_in = itad_pkg::ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = itad_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itad_pkg::ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         neg_ff       <= 1'b0;
         left_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         neg_ff       <= neg_in;
         left_ff      <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff    <= digits_in;
      upper_ff     <= upper_in;
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
      out_total_ff <= out_total_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.char_out    = out_char_ff;
   assign rsp_chan.is_last     = out_last_ff;
   assign rsp_chan.chars_total = out_total_ff;

`ifndef SYNTH
   a_done_in_convert: assert property (@(posedge clock) disable iff (reset)
      cvt_rsp.done |-> state_ff == itad_pkg::ST_CONVERT)
      else $error("converter done outside convert state");

   a_digits_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == itad_pkg::ST_SKIP || state_ff == itad_pkg::ST_EMIT) |-> left_ff != '0)
      else $error("no digits left while printing");

   a_more_to_come: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_last_ff) |-> state_ff == itad_pkg::ST_EMIT)
      else $error("number ended without a last character");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == itad_pkg::ST_EMIT && slot_free) |=>
         count_ff == COUNT_BITS'($past(count_ff) + 1'b1))
      else $error("character count did not advance by one");
`endif

endmodule

`default_nettype wire
